// ===== hw/rtl/cdr_pkg.sv =====
`default_nettype none

package cdr_pkg;

  localparam int WordBits = 32;
  localparam int OffBits  = 7;
  localparam int CntBits  = 8;
  localparam int LineBits = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [OffBits-1:0] OFF_A_CLK = 7'h00;
  localparam logic [OffBits-1:0] OFF_A_RDY = 7'h04;
  localparam logic [OffBits-1:0] OFF_A_STA = 7'h08;
  localparam logic [OffBits-1:0] OFF_A_TSK = 7'h0C;
  localparam logic [OffBits-1:0] OFF_A_DAT = 7'h10;
  localparam logic [OffBits-1:0] OFF_A_RET = 7'h14;
  localparam logic [OffBits-1:0] OFF_A_DON = 7'h18;
  localparam logic [OffBits-1:0] OFF_C_CLK = 7'h40;
  localparam logic [OffBits-1:0] OFF_C_BIN = 7'h44;
  localparam logic [OffBits-1:0] OFF_C_NBW = 7'h48;
  localparam logic [OffBits-1:0] OFF_C_DON = 7'h4C;
  localparam logic [OffBits-1:0] OFF_C_TSK = 7'h50;
  localparam logic [OffBits-1:0] OFF_C_DAT = 7'h54;
  localparam logic [OffBits-1:0] OFF_C_STA = 7'h58;
  localparam logic [OffBits-1:0] OFF_C_RDY = 7'h5C;

  typedef enum logic [3:0] {
    REG_A_CLK,
    REG_A_RDY,
    REG_A_STA,
    REG_A_TSK,
    REG_A_DAT,
    REG_A_RET,
    REG_A_DON,
    REG_C_CLK,
    REG_C_BIN,
    REG_C_NBW,
    REG_C_DON,
    REG_C_TSK,
    REG_C_DAT,
    REG_C_STA,
    REG_C_RDY,
    REG_NONE
  } reg_id_t;

  typedef struct packed {
    logic    rd;
    logic    wr;
    logic    tick;
    reg_id_t reg_id;
  } dec_t;

  typedef struct packed {
    logic step;
  } cmd_t;

  localparam logic [WordBits-1:0] ONE_WORD = 32'h0000_0001;

endpackage

`default_nettype wire

// ===== hw/rtl/cluster_task_dispatch_regs_unit.sv =====
// Task dispatch register block for one accelerator and a core cluster.
// Input channel (in_valid/in_ready) carries one word per access: operation
// (bus read 0, bus write 1, clock tick 2), byte offset and write data.
// Result channel (out_valid/out_ready) returns one word per access: the
// read data and error flag of that access, plus the levels of the clock
// enable, start and done lines and the entry point as they stand after it.
// The result of a word accepted at one edge is valid from the next cycle.
// The controller handles one access at a time: after accepting a word it
// takes no new word until the receiver has taken that access's result.
// When out_ready is low the result and all line levels hold, and in_ready
// stays low until the result is taken.
// Synchronous reset (rst_n low) clears every counter, line, pending clear
// and stored word but the result, and readies the block for a new access.
// Line levels only change when an access is accepted; between accesses
// the output ports keep their last values.
`default_nettype none

module cluster_task_dispatch_regs_unit #(
  parameter int NUM_CORES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [6:0]  in_offset,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic             out_access_error,
  output logic             out_accel_clock_enable,
  output logic             out_accel_start_irq,
  output logic             out_accel_done_irq,
  output logic             out_cluster_clock_enable,
  output logic [7:0]       out_core_start_irqs,
  output logic             out_cluster_done_irq,
  output logic [31:0]      out_entry_point
);
  import cdr_pkg::*;

  cmd_t cmd;
  dec_t dec;

  cdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cdr_decode u_decode (
    .op     (in_operation),
    .offset (in_offset),
    .dec    (dec)
  );

  cdr_datapath #(
    .NUM_CORES (NUM_CORES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .dec                  (dec),
    .wdata                (in_write_data),
    .read_data            (out_read_data),
    .access_error         (out_access_error),
    .accel_clock_enable   (out_accel_clock_enable),
    .accel_start_irq      (out_accel_start_irq),
    .accel_done_irq       (out_accel_done_irq),
    .cluster_clock_enable (out_cluster_clock_enable),
    .core_start_irqs      (out_core_start_irqs),
    .cluster_done_irq     (out_cluster_done_irq),
    .entry_point          (out_entry_point)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cdr_decode.sv =====
`default_nettype none

module cdr_decode (
  input  wire logic [1:0]                 op,
  input  wire logic [cdr_pkg::OffBits-1:0] offset,
  output cdr_pkg::dec_t                   dec
);
  import cdr_pkg::*;

  always_comb begin
    dec.rd   = (op_t'(op) == OP_READ);
    dec.wr   = (op_t'(op) == OP_WRITE);
    dec.tick = (op_t'(op) == OP_TICK);
    unique case (offset)
      OFF_A_CLK: dec.reg_id = REG_A_CLK;
      OFF_A_RDY: dec.reg_id = REG_A_RDY;
      OFF_A_STA: dec.reg_id = REG_A_STA;
      OFF_A_TSK: dec.reg_id = REG_A_TSK;
      OFF_A_DAT: dec.reg_id = REG_A_DAT;
      OFF_A_RET: dec.reg_id = REG_A_RET;
      OFF_A_DON: dec.reg_id = REG_A_DON;
      OFF_C_CLK: dec.reg_id = REG_C_CLK;
      OFF_C_BIN: dec.reg_id = REG_C_BIN;
      OFF_C_NBW: dec.reg_id = REG_C_NBW;
      OFF_C_DON: dec.reg_id = REG_C_DON;
      OFF_C_TSK: dec.reg_id = REG_C_TSK;
      OFF_C_DAT: dec.reg_id = REG_C_DAT;
      OFF_C_STA: dec.reg_id = REG_C_STA;
      OFF_C_RDY: dec.reg_id = REG_C_RDY;
      default:   dec.reg_id = REG_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdr_ctrl.sv =====
`default_nettype none

module cdr_ctrl (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cdr_pkg::cmd_t cmd
);
  import cdr_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_HOLD
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign cmd.step  = in_valid & in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r     <= ST_HOLD;
            in_ready_r  <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        ST_HOLD: begin
          // hold the result word until the receiver takes it
          if (out_ready) begin
            state_r     <= ST_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid)
    else $error("accepted word produced no result");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && !in_ready))
    else $error("result dropped under stall");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cdr_datapath.sv =====
`default_nettype none

module cdr_datapath #(
  parameter int NUM_CORES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cdr_pkg::cmd_t                cmd,
  input  wire cdr_pkg::dec_t                dec,
  input  wire logic [cdr_pkg::WordBits-1:0] wdata,
  output logic [cdr_pkg::WordBits-1:0]      read_data,
  output logic                              access_error,
  output logic                              accel_clock_enable,
  output logic                              accel_start_irq,
  output logic                              accel_done_irq,
  output logic                              cluster_clock_enable,
  output logic [cdr_pkg::LineBits-1:0]      core_start_irqs,
  output logic                              cluster_done_irq,
  output logic [cdr_pkg::WordBits-1:0]      entry_point
);
  import cdr_pkg::*;

  localparam int StartBits = (NUM_CORES < LineBits) ? NUM_CORES : LineBits;
  localparam logic [LineBits-1:0] StartMask =
    LineBits'((9'd1 << StartBits) - 9'd1);
  localparam logic [CntBits-1:0] ReadyTarget = CntBits'(NUM_CORES);

  logic [WordBits-1:0] a_clk_r, a_rdy_r, a_sta_r, a_tsk_r, a_dat_r, a_ret_r;
  logic [WordBits-1:0] c_clk_r, c_bin_r, c_nbw_r, c_tsk_r, c_dat_r, c_sta_r;
  logic [WordBits-1:0] a_clk_nxt, a_rdy_nxt, a_sta_nxt, a_tsk_nxt, a_dat_nxt, a_ret_nxt;
  logic [WordBits-1:0] c_clk_nxt, c_bin_nxt, c_nbw_nxt, c_tsk_nxt, c_dat_nxt, c_sta_nxt;
  logic                rdy_flag_r, rdy_flag_nxt;
  logic [CntBits-1:0]  ack_cnt_r, ack_cnt_nxt;
  logic [CntBits-1:0]  done_cnt_r, done_cnt_nxt;
  logic [CntBits-1:0]  rdy_cnt_r, rdy_cnt_nxt;
  logic                aclk_r, aclk_nxt, astart_r, astart_nxt, adone_r, adone_nxt;
  logic                cclk_r, cclk_nxt, cdone_r, cdone_nxt;
  logic [LineBits-1:0] start_r, start_nxt;
  // pending clears: [0] accel done, [1] cluster done, [2] core start lines
  logic [2:0]          pend_r, pend_nxt;
  logic [WordBits-1:0] rd_r, rd_nxt;
  logic                err_r, err_nxt;
  logic [CntBits-1:0]  ack_inc, done_inc, rdy_inc;

  function automatic logic is_target(logic [CntBits-1:0] c, logic [WordBits-1:0] t);
    return (t != '0) && ({{(WordBits-CntBits){1'b0}}, c} == t);
  endfunction

  assign ack_inc  = ack_cnt_r + 1'b1;
  assign done_inc = done_cnt_r + 1'b1;
  assign rdy_inc  = rdy_cnt_r + 1'b1;

  always_comb begin
    a_clk_nxt = a_clk_r; a_rdy_nxt = a_rdy_r; a_sta_nxt = a_sta_r;
    a_tsk_nxt = a_tsk_r; a_dat_nxt = a_dat_r; a_ret_nxt = a_ret_r;
    c_clk_nxt = c_clk_r; c_bin_nxt = c_bin_r; c_nbw_nxt = c_nbw_r;
    c_tsk_nxt = c_tsk_r; c_dat_nxt = c_dat_r; c_sta_nxt = c_sta_r;
    rdy_flag_nxt = rdy_flag_r;
    ack_cnt_nxt  = ack_cnt_r;
    done_cnt_nxt = done_cnt_r;
    rdy_cnt_nxt  = rdy_cnt_r;
    aclk_nxt = aclk_r; astart_nxt = astart_r; adone_nxt = adone_r;
    cclk_nxt = cclk_r; cdone_nxt = cdone_r;
    start_nxt = start_r;
    pend_nxt  = pend_r;
    rd_nxt    = '0;
    err_nxt   = 1'b0;

    if (dec.rd) begin
      unique case (dec.reg_id)
        REG_A_CLK: rd_nxt = a_clk_r;
        REG_A_RDY: rd_nxt = a_rdy_r;
        REG_A_STA: rd_nxt = a_sta_r;
        REG_A_TSK: rd_nxt = a_tsk_r;
        REG_A_DAT: rd_nxt = a_dat_r;
        REG_A_RET: rd_nxt = a_ret_r;
        REG_A_DON: err_nxt = 1'b1;
        REG_C_CLK: rd_nxt = c_clk_r;
        REG_C_BIN: rd_nxt = c_bin_r;
        REG_C_NBW: rd_nxt = c_nbw_r;
        REG_C_DON: err_nxt = 1'b1;
        REG_C_TSK: rd_nxt = c_tsk_r;
        REG_C_DAT: rd_nxt = c_dat_r;
        REG_C_STA: rd_nxt = c_sta_r;
        REG_C_RDY: rd_nxt = rdy_flag_r ? ONE_WORD : '0;
        default:   rd_nxt = '0;
      endcase
    end else if (dec.wr) begin
      unique case (dec.reg_id)
        REG_A_CLK: begin
          a_clk_nxt = wdata;
          if (wdata <= ONE_WORD) aclk_nxt = wdata[0];
          else err_nxt = 1'b1;
        end
        REG_A_RDY: a_rdy_nxt = wdata;
        REG_A_STA: begin
          a_sta_nxt = wdata;
          if (wdata <= ONE_WORD) astart_nxt = wdata[0];
          else err_nxt = 1'b1;
        end
        REG_A_TSK: a_tsk_nxt = wdata;
        REG_A_DAT: a_dat_nxt = wdata;
        REG_A_RET: a_ret_nxt = wdata;
        REG_A_DON: begin
          adone_nxt   = 1'b1;
          pend_nxt[0] = 1'b1;
        end
        REG_C_CLK: begin
          c_clk_nxt    = wdata;
          rdy_cnt_nxt  = '0;
          rdy_flag_nxt = 1'b0;
          cclk_nxt     = (wdata != '0);
        end
        REG_C_BIN: c_bin_nxt = wdata;
        REG_C_NBW: c_nbw_nxt = wdata;
        REG_C_DON: begin
          done_cnt_nxt = done_inc;
          if (is_target(done_inc, c_nbw_r)) begin
            done_cnt_nxt = '0;
            cdone_nxt    = 1'b1;
            pend_nxt[1]  = 1'b1;
          end
        end
        REG_C_TSK: c_tsk_nxt = wdata;
        REG_C_DAT: c_dat_nxt = wdata;
        REG_C_STA: begin
          if (wdata != '0) begin
            c_sta_nxt    = wdata;
            ack_cnt_nxt  = '0;
            done_cnt_nxt = '0;
            start_nxt    = start_r | (wdata[LineBits-1:0] & StartMask);
            pend_nxt[2]  = 1'b1;
          end else begin
            ack_cnt_nxt = ack_inc;
            if (is_target(ack_inc, c_nbw_r)) c_sta_nxt = '0;
          end
        end
        REG_C_RDY: begin
          rdy_cnt_nxt = rdy_inc;
          if (rdy_inc == ReadyTarget) rdy_flag_nxt = 1'b1;
        end
        default: ;
      endcase
    end else if (dec.tick) begin
      // drop every pulsed line that is still pending
      if (pend_r[0]) adone_nxt = 1'b0;
      if (pend_r[1]) cdone_nxt = 1'b0;
      if (pend_r[2]) start_nxt = '0;
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_clk_r <= '0; a_rdy_r <= '0; a_sta_r <= '0;
      a_tsk_r <= '0; a_dat_r <= '0; a_ret_r <= '0;
      c_clk_r <= '0; c_bin_r <= '0; c_nbw_r <= '0;
      c_tsk_r <= '0; c_dat_r <= '0; c_sta_r <= '0;
      rdy_flag_r <= 1'b0;
      ack_cnt_r  <= '0;
      done_cnt_r <= '0;
      rdy_cnt_r  <= '0;
      aclk_r <= 1'b0; astart_r <= 1'b0; adone_r <= 1'b0;
      cclk_r <= 1'b0; cdone_r <= 1'b0;
      start_r <= '0;
      pend_r  <= '0;
    end else if (cmd.step) begin
      a_clk_r <= a_clk_nxt; a_rdy_r <= a_rdy_nxt; a_sta_r <= a_sta_nxt;
      a_tsk_r <= a_tsk_nxt; a_dat_r <= a_dat_nxt; a_ret_r <= a_ret_nxt;
      c_clk_r <= c_clk_nxt; c_bin_r <= c_bin_nxt; c_nbw_r <= c_nbw_nxt;
      c_tsk_r <= c_tsk_nxt; c_dat_r <= c_dat_nxt; c_sta_r <= c_sta_nxt;
      rdy_flag_r <= rdy_flag_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
      done_cnt_r <= done_cnt_nxt;
      rdy_cnt_r  <= rdy_cnt_nxt;
      aclk_r <= aclk_nxt; astart_r <= astart_nxt; adone_r <= adone_nxt;
      cclk_r <= cclk_nxt; cdone_r <= cdone_nxt;
      start_r <= start_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_r  <= rd_nxt;
      err_r <= err_nxt;
    end
  end

  assign read_data            = rd_r;
  assign access_error         = err_r;
  assign accel_clock_enable   = aclk_r;
  assign accel_start_irq      = astart_r;
  assign accel_done_irq       = adone_r;
  assign cluster_clock_enable = cclk_r;
  assign core_start_irqs      = start_r;
  assign cluster_done_irq     = cdone_r;
  assign entry_point          = c_bin_r;

`ifndef SYNTHESIS
  a_adone_pending: assert property (@(posedge clk) disable iff (!rst_n)
    adone_r |-> pend_r[0])
    else $error("accel done line high without a pending clear");
  a_cdone_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cdone_r |-> pend_r[1])
    else $error("cluster done line high without a pending clear");
  a_start_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r != '0) |-> pend_r[2])
    else $error("core start lines high without a pending clear");
  a_tick_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && dec.tick) |=> (!adone_r && !cdone_r && start_r == '0))
    else $error("tick left a pulsed line high");
`endif

endmodule

`default_nettype wire
